>>> hdl/jssr_pkg.sv
// jssr_pkg: shared types and constants for the joint setpoint slew ramp
// holds field widths, register indexes, item kinds and the lane result struct
// no dependencies
package jssr_pkg;

    // fixed field widths
    localparam int LANES      = 6;
    localparam int POS_W      = 20;
    localparam int BASE_W     = 16;
    localparam int TOL_W      = 16;
    localparam int JOINT_W    = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_STEP      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_FROM_MEAS = 2'd2;

    // configuration reset values
    localparam logic [BASE_W-1:0] BASE_STEP_RST = 16'd262;
    localparam logic [TOL_W-1:0]  TOLERANCE_RST = 16'd66;

    // input item kinds
    localparam logic KIND_GOAL = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef logic signed [POS_W-1:0] t_pos;

    // per-joint update status handed from a lane to the top level
    typedef struct packed {
        t_pos next_cmd;
        logic moved;
    } t_lane_res;

endpackage

>>> hdl/joint_setpoint_slew_ramp.sv
// Joint setpoint slew ramp: keeps a goal and a commanded position for up to six
// joints and, on every control tick, moves each unsettled command toward its goal
// by a step that scales with the measured tracking error. The block takes one
// item per clock cycle (goal write or tick) unless o_in_stall holds it. A tick
// waits in the input register while the six parallel lanes (one 16 x 21 bit
// multiply each) compute its update, and its result is then loaded into the
// result register, from which it transfers out.
// Goal writes produce no result. Items are processed strictly in order, so a
// goal write followed by a tick in the next cycle is seen by that tick. The
// output register holds a result under stall while a new item is still taken
// into the input register. Configuration is written through the plain write
// port, by the user only while the block is idle; the block does not enforce it.
// depends on jssr_pkg and jssr_lane
module joint_setpoint_slew_ramp #(
    parameter int NUM_JOINTS    = 6,
    parameter int POS_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [jssr_pkg::JOINT_W-1:0]        i_joint,
    input  jssr_pkg::t_pos                      i_goal_value,
    input  jssr_pkg::t_pos                      i_measured_0,
    input  jssr_pkg::t_pos                      i_measured_1,
    input  jssr_pkg::t_pos                      i_measured_2,
    input  jssr_pkg::t_pos                      i_measured_3,
    input  jssr_pkg::t_pos                      i_measured_4,
    input  jssr_pkg::t_pos                      i_measured_5,

    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output jssr_pkg::t_pos                      o_command_0,
    output jssr_pkg::t_pos                      o_command_1,
    output jssr_pkg::t_pos                      o_command_2,
    output jssr_pkg::t_pos                      o_command_3,
    output jssr_pkg::t_pos                      o_command_4,
    output jssr_pkg::t_pos                      o_command_5,
    output logic                                o_all_reached,

    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [jssr_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [jssr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    // configuration registers
    logic [jssr_pkg::BASE_W-1:0] r_base_step;
    logic [jssr_pkg::TOL_W-1:0]  r_tolerance;
    logic                        r_init_cfg;
    logic                        r_init;

    // input register
    logic                         r_in_valid;
    logic                         r_in_kind;
    logic [jssr_pkg::JOINT_W-1:0] r_in_joint;
    jssr_pkg::t_pos               r_in_goal;
    jssr_pkg::t_pos               r_in_meas [jssr_pkg::LANES];

    // result register
    logic                         r_out_valid;
    jssr_pkg::t_pos               r_out_cmd [jssr_pkg::LANES];
    logic                         r_out_all;

    jssr_pkg::t_pos               w_meas    [jssr_pkg::LANES];
    jssr_pkg::t_pos               w_out_cmd [jssr_pkg::LANES];
    logic [jssr_pkg::LANES-1:0]   w_moved;
    logic                         w_in_xfer;
    logic                         w_out_xfer;
    logic                         w_fire;
    logic                         w_tick_fire;
    logic                         w_goal_fire;
    logic                         n_load_init;

    assign w_meas[0] = i_measured_0;
    assign w_meas[1] = i_measured_1;
    assign w_meas[2] = i_measured_2;
    assign w_meas[3] = i_measured_3;
    assign w_meas[4] = i_measured_4;
    assign w_meas[5] = i_measured_5;

    // handshake and stage advance
    assign w_out_xfer  = r_out_valid && !i_out_stall;
    assign w_fire      = r_in_valid &&
                         ((r_in_kind == jssr_pkg::KIND_GOAL) || !r_out_valid || !i_out_stall);
    assign w_tick_fire = w_fire && (r_in_kind == jssr_pkg::KIND_TICK);
    assign w_goal_fire = w_fire && (r_in_kind == jssr_pkg::KIND_GOAL);
    assign o_in_stall  = r_in_valid && !w_fire;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign n_load_init = !r_init && r_init_cfg;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_step <= jssr_pkg::BASE_STEP_RST;
            r_tolerance <= jssr_pkg::TOLERANCE_RST;
            r_init_cfg  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                jssr_pkg::CFG_BASE_STEP:      r_base_step <= i_cfg_wdata;
                jssr_pkg::CFG_TOLERANCE:      r_tolerance <= i_cfg_wdata;
                jssr_pkg::CFG_INIT_FROM_MEAS: r_init_cfg  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // initialization flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 1'b0;
        end else if (w_tick_fire && n_load_init) begin
            r_init <= 1'b1;
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_kind  <= i_kind;
            r_in_joint <= i_joint;
            r_in_goal  <= i_goal_value;
            for (int i = 0; i < jssr_pkg::LANES; i++) begin
                r_in_meas[i] <= w_meas[i];
            end
        end
    end

    // per-joint state and lanes
    for (genvar g = 0; g < jssr_pkg::LANES; g++) begin : gen_lane
        if (g < NUM_JOINTS) begin : gen_used
            jssr_pkg::t_pos      r_cmd;
            jssr_pkg::t_pos      r_goal;
            jssr_pkg::t_pos      w_cmd_eff;
            jssr_pkg::t_lane_res w_res;

            assign w_cmd_eff = n_load_init ? r_in_meas[g] : r_cmd;

            jssr_lane #(
                .POS_FRAC_BITS (POS_FRAC_BITS)
            ) u_lane (
                .i_cmd         (w_cmd_eff),
                .i_goal        (r_goal),
                .i_measured    (r_in_meas[g]),
                .i_base_step   (r_base_step),
                .i_tolerance   (r_tolerance),
                .o_res         (w_res)
            );

            assign w_moved[g]   = w_res.moved;
            assign w_out_cmd[g] = w_res.moved ? w_res.next_cmd : r_goal;

            // command update on ticks
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cmd <= '0;
                end else if (w_tick_fire) begin
                    r_cmd <= w_res.next_cmd;
                end
            end

            // goal update on goal items
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_goal <= '0;
                end else if (w_goal_fire && (r_in_joint == jssr_pkg::JOINT_W'(g))) begin
                    r_goal <= r_in_goal;
                end
            end
        end else begin : gen_unused
            assign w_moved[g]   = 1'b0;
            assign w_out_cmd[g] = '0;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tick_fire) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_tick_fire) begin
            r_out_all <= ~|w_moved;
            for (int i = 0; i < jssr_pkg::LANES; i++) begin
                r_out_cmd[i] <= w_out_cmd[i];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_all_reached = r_out_all;
    assign o_command_0   = r_out_cmd[0];
    assign o_command_1   = r_out_cmd[1];
    assign o_command_2   = r_out_cmd[2];
    assign o_command_3   = r_out_cmd[3];
    assign o_command_4   = r_out_cmd[4];
    assign o_command_5   = r_out_cmd[5];

`ifndef SYNTH
    // once loaded from measurements the commands are never reloaded
    a_init_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |=> r_init)
        else $error("initialized flag dropped");

    // only a tick blocked by a full, stalled result register stalls the input
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && (r_in_kind == jssr_pkg::KIND_TICK)
                        && r_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // a tick leaving the input register always lands a result
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick_fire |=> o_out_valid)
        else $error("tick produced no result");

    // goal items never create a result
    a_goal_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_in_kind == jssr_pkg::KIND_GOAL) && !r_out_valid)
        |=> !o_out_valid)
        else $error("goal item produced a result");
`endif

endmodule

>>> hdl/jssr_lane.sv
// jssr_lane: one joint's slew update, purely combinational
// computes the rate-scaled step, clamps it to the goal and flags movement
// depends on jssr_pkg
module jssr_lane #(
    parameter int POS_FRAC_BITS = 16
) (
    input  jssr_pkg::t_pos                    i_cmd,
    input  jssr_pkg::t_pos                    i_goal,
    input  jssr_pkg::t_pos                    i_measured,
    input  logic [jssr_pkg::BASE_W-1:0]       i_base_step,
    input  logic [jssr_pkg::TOL_W-1:0]        i_tolerance,
    output jssr_pkg::t_lane_res               o_res
);

    localparam int DW = jssr_pkg::POS_W + 1;
    localparam int FW = ((POS_FRAC_BITS + 2 > DW) ? POS_FRAC_BITS + 2 : DW) + 1;
    localparam int PW = jssr_pkg::BASE_W + FW - 1;
    localparam int SW = PW - POS_FRAC_BITS - 1;
    localparam int CW = (SW > DW) ? SW : DW;
    localparam logic signed [FW-1:0] FACT_ONE = FW'(1) << (POS_FRAC_BITS + 1);

    logic signed [DW-1:0] w_dist;
    logic signed [DW-1:0] w_err;
    logic        [DW-1:0] w_adist;
    logic                 w_moved;
    logic signed [FW-1:0] w_factor;
    logic                 w_fact_pos;
    logic        [PW-1:0] w_prod;
    logic        [SW-1:0] w_step;
    logic        [CW-1:0] w_step_ext;
    logic        [CW-1:0] w_adist_ext;
    logic        [CW-1:0] w_clamp;
    logic        [DW-1:0] w_clamp_n;
    logic        [DW-1:0] w_next;

    // distance to goal and reach test
    assign w_dist  = DW'(i_goal) - DW'(i_cmd);
    assign w_adist = w_dist[DW-1] ? DW'(-w_dist) : DW'(w_dist);
    assign w_moved = w_adist > DW'(i_tolerance);

    // step = base * (1 + err/2), with one at 2^(frac+1)
    assign w_err      = DW'(i_measured) - DW'(i_cmd);
    assign w_factor   = FACT_ONE + FW'(w_err);
    assign w_fact_pos = !w_factor[FW-1] && (w_factor != '0);
    assign w_prod     = PW'(i_base_step) * PW'(w_factor[FW-2:0]);
    assign w_step     = w_fact_pos ? w_prod[PW-1:POS_FRAC_BITS+1] : '0;

    // never overshoot the goal
    assign w_step_ext  = CW'(w_step);
    assign w_adist_ext = CW'(w_adist);
    assign w_clamp     = (w_step_ext > w_adist_ext) ? w_adist_ext : w_step_ext;
    assign w_clamp_n   = w_clamp[DW-1:0];

    // move toward the goal
    assign w_next = w_dist[DW-1] ? (DW'(i_cmd) - w_clamp_n) : (DW'(i_cmd) + w_clamp_n);

    assign o_res.moved    = w_moved;
    assign o_res.next_cmd = w_moved ? w_next[jssr_pkg::POS_W-1:0] : i_cmd;

endmodule
